>>> src/bounded_list_deque_engine_macros.svh
// assertion macros for the bounded list deque engine
// used by the top level; expects a clock named i_clk and a reset named i_rst_n
`ifndef BOUNDED_LIST_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_LIST_DEQUE_ENGINE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define BLD_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("bounded_list_deque_engine: same-cycle check failed");

// condition holds in the cycle after the trigger
`define BLD_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("bounded_list_deque_engine: next-cycle check failed");

`endif

>>> src/bld_pkg.sv
// shared types and codes for the bounded list deque engine
// no dependencies
`default_nettype none

package bld_pkg;

    // fixed field widths of the command and response
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // default sizing
    localparam int DEPTH_DEF      = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_HEAD  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ_INDEX = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_TAKE       = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_DROP       = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_READ_LEN   = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // command transfer
    typedef struct packed {
        logic        [OPCODE_W-1:0] opcode;
        logic signed [VALUE_W-1:0]  value;
        logic        [COUNT_W-1:0]  count;
    } t_cmd;

    // response transfer
    typedef struct packed {
        logic signed [VALUE_W-1:0]  data;
        logic        [COUNT_W-1:0]  length;
        logic        [STATUS_W-1:0] status;
    } t_rsp;

    // response fields known at issue time, handed from control to the top
    typedef struct packed {
        logic                rd_ok;
        logic [COUNT_W-1:0]  length;
        logic [STATUS_W-1:0] status;
    } t_meta;

endpackage

`default_nettype wire

>>> src/bounded_list_deque_engine.sv
// top level of the bounded list deque engine: ring of elements in one ram
// depends on bld_pkg, bld_ctrl, bld_ram and bounded_list_deque_engine_macros.svh
//
//   channel   | ports                  | transfer when
//   ----------+------------------------+---------------------------
//   command   | i_start, i_cmd, o_busy | i_start high and o_busy low
//   response  | o_valid, o_rsp         | o_valid high, one cycle
//
// one command per cycle; its response appears in the cycle after the transfer,
// set by the registered read of the element ram.
// every command is at most one ram access (write or read) plus a pointer and count update.
// o_busy is high only in reset and in the first cycle after it; no clearing pass is needed.
// the receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none

`include "bounded_list_deque_engine_macros.svh"

module bounded_list_deque_engine
    import bld_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    output logic      o_busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                   run;
    logic                   accept;
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_addr;
    logic [ELEM_WIDTH-1:0]  mem_wdata;
    logic [ELEM_WIDTH-1:0]  mem_rdata;
    logic signed [ELEM_WIDTH-1:0] rd_elem;
    t_meta                  meta;

    // command handshake
    assign accept = i_start && run;
    assign o_busy = !run;

    // command decode and ring pointers
    bld_ctrl #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .o_run       (run),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .o_valid     (o_valid),
        .o_meta      (meta)
    );

    // element store
    bld_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // response assembly, read data sign-extended or cut to the field width
    assign rd_elem      = mem_rdata;
    assign o_rsp.data   = meta.rd_ok ? VALUE_W'(rd_elem) : '0;
    assign o_rsp.length = meta.length;
    assign o_rsp.status = meta.status;

    // checks
    `BLD_ASSERT_NEXT(a_rsp_follows_cmd, accept, o_valid)
    `BLD_ASSERT_NEXT(a_no_spurious_rsp, !accept, !o_valid)
    `BLD_ASSERT_SAME(a_err_data_zero, o_valid && (o_rsp.status != ST_OK), o_rsp.data == '0)
    `BLD_ASSERT_SAME(a_rd_ok_status, o_valid && meta.rd_ok, o_rsp.status == ST_OK)

endmodule

`default_nettype wire

>>> src/bld_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module bld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // at most one write and one read per cycle, at the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/bld_ctrl.sv
// command decode, ring pointer and element count for the deque engine
// depends on bld_pkg; drives the element ram address and write port
`default_nettype none

module bld_ctrl
    import bld_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire t_cmd                     i_cmd,
    output logic                          o_run,
    output logic                          o_mem_we,
    output logic                          o_mem_re,
    output logic [$clog2(DEPTH)-1:0]      o_mem_addr,
    output logic [ELEM_WIDTH-1:0]         o_mem_wdata,
    output logic                          o_valid,
    output t_meta                         o_meta
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] RING_SIZE = SW'(DEPTH);

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_run;
    logic          r_valid;
    t_meta         r_meta, n_meta;

    logic [XW-1:0] n_ext;
    logic [XW-1:0] cnt_ext;
    logic [CW-1:0] n_clip;
    logic [CW-1:0] off;
    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;
    logic [AW-1:0] slot;
    logic [AW-1:0] front_dec;
    logic          full;
    logic          empty;

    // operand widening and clipping of the drop count
    assign n_ext   = XW'(i_cmd.count);
    assign cnt_ext = XW'(r_cnt);
    assign n_clip  = (n_ext > cnt_ext) ? r_cnt : CW'(n_ext);
    assign full    = (r_cnt == FULL_CNT);
    assign empty   = (r_cnt == '0);

    // offset select for the shared ring adder
    always_comb begin
        case (i_cmd.opcode)
            OP_PUSH_BACK: off = r_cnt;
            OP_POP_FRONT: off = CW'(1);
            OP_DROP:      off = n_clip;
            default:      off = CW'(n_ext);
        endcase
    end

    // front plus offset, wrapped once (sum stays below twice the depth wherever the slot is used)
    assign sum       = SW'(r_front) + SW'(off);
    assign wrapped   = (sum >= RING_SIZE) ? (sum - RING_SIZE) : sum;
    assign slot      = wrapped[AW-1:0];
    assign front_dec = (r_front == '0) ? LAST_SLOT : (r_front - AW'(1));

    // command decode
    always_comb begin
        n_front       = r_front;
        n_cnt         = r_cnt;
        o_mem_we      = 1'b0;
        o_mem_re      = 1'b0;
        o_mem_addr    = r_front;
        o_mem_wdata   = ELEM_WIDTH'(i_cmd.value);
        n_meta.rd_ok  = 1'b0;
        n_meta.status = ST_OK;
        if (i_accept) begin
            unique case (i_cmd.opcode)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_meta.status = ST_FULL;
                    end else begin
                        o_mem_we   = 1'b1;
                        o_mem_addr = front_dec;
                        n_front    = front_dec;
                        n_cnt      = r_cnt + CW'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        n_meta.status = ST_FULL;
                    end else begin
                        o_mem_we   = 1'b1;
                        o_mem_addr = slot;
                        n_cnt      = r_cnt + CW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        n_meta.status = ST_EMPTY;
                    end else begin
                        o_mem_re     = 1'b1;
                        n_meta.rd_ok = 1'b1;
                        n_front      = slot;
                        n_cnt        = r_cnt - CW'(1);
                    end
                end
                OP_READ_HEAD: begin
                    if (empty) begin
                        n_meta.status = ST_EMPTY;
                    end else begin
                        o_mem_re     = 1'b1;
                        n_meta.rd_ok = 1'b1;
                    end
                end
                OP_READ_INDEX: begin
                    if (n_ext >= cnt_ext) begin
                        n_meta.status = ST_EMPTY;
                    end else begin
                        o_mem_re     = 1'b1;
                        o_mem_addr   = slot;
                        n_meta.rd_ok = 1'b1;
                    end
                end
                OP_TAKE: begin
                    if (n_ext < cnt_ext) begin
                        n_cnt = CW'(n_ext);
                    end
                end
                OP_DROP: begin
                    n_front = slot;
                    n_cnt   = r_cnt - n_clip;
                end
                OP_READ_LEN: begin
                end
                default: begin
                end
            endcase
        end
        n_meta.length = COUNT_W'(n_cnt);
    end

    // pointer, count and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_cnt   <= '0;
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_cnt   <= n_cnt;
            r_run   <= 1'b1;
            r_valid <= i_accept;
        end
    end

    // response fields, captured with the command
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_meta <= n_meta;
        end
    end

    assign o_run   = r_run;
    assign o_valid = r_valid;
    assign o_meta  = r_meta;

endmodule

`default_nettype wire
